/* hw/rtl/interlock_debounce_downtime_meter_assert.svh */
// Assertion macros used by the interlock monitor checker
`ifndef INTERLOCK_DEBOUNCE_DOWNTIME_METER_ASSERT_SVH
`define INTERLOCK_DEBOUNCE_DOWNTIME_METER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent
`define IDM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define IDM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/idm_pkg.sv */
// Types and constants for the interlock debounce and downtime meter
`default_nettype none

package idm_pkg;

   // Command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
   localparam logic [15:0] HOLD_RESET = 16'd500;

   typedef struct packed {
      logic [1:0] command;
      logic       power_sense;
      logic       interlock_level;
   } req_type;

   typedef struct packed {
      logic        power_down;
      logic [31:0] max_down_ms;
      logic        measuring_active;
      logic        interval_open;
   } rsp_type;

   // Post-update view of the meter state
   typedef struct packed {
      logic        measuring;
      logic        open;
      logic [31:0] longest;
   } meter_view_type;

endpackage

`default_nettype wire

/* hw/rtl/interlock_debounce_downtime_meter.sv */
// A result appears the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while results are taken; the result register frees as it is taken.
// Every transaction gives exactly one result showing the state after its update.
// Reset (synchronous): power on, not down, measuring off, hold limit 500 ms.
// The hold limit may be rewritten through the csr port at any idle cycle.
`default_nettype none

module interlock_debounce_downtime_meter
   import idm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [15:0]    hold_ms_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   logic           take;
   logic           down_next;
   meter_view_type meter_next;

   // Accept whenever the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   // Hold-time register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ms_ff <= HOLD_RESET;
      end else if (csr_wr_en) begin
         hold_ms_ff <= csr_wr_data;
      end
   end

   idm_debounce u_debounce (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req       (req_data),
      .hold      (hold_ms_ff),
      .down_next (down_next)
   );

   idm_meter u_meter (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req       (req_data),
      .view_next (meter_next)
   );

   // Build the result from the post-update state
   always_comb begin
      rsp_data_in.power_down       = down_next;
      rsp_data_in.max_down_ms      = meter_next.longest;
      rsp_data_in.measuring_active = meter_next.measuring;
      rsp_data_in.interval_open    = meter_next.open;
      rsp_valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load result payload on accept
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/idm_debounce.sv */
// Asymmetric power-sense debounce: fast clear, held-low declaration of down
`default_nettype none

module idm_debounce
   import idm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        take,
   input  wire req_type     req,
   input  wire logic [15:0] hold,
   output logic             down_next
);

   logic        last_on_ff, last_on_in;
   logic        down_ff, down_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] count_inc;

   // Update debounce state on accepted ticks
   always_comb begin
      last_on_in = last_on_ff;
      down_in    = down_ff;
      count_in   = count_ff;
      count_inc  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 32'd1;
      if (take && (req.command == CMD_TICK)) begin
         if (req.power_sense) begin
            last_on_in = 1'b1;
            down_in    = 1'b0;
         end else if (last_on_ff) begin
            last_on_in = 1'b0;
            count_in   = '0;
         end else begin
            count_in = count_inc;
            if (count_inc > {16'd0, hold}) begin
               down_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_on_ff <= 1'b1;
         down_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         last_on_ff <= last_on_in;
         down_ff    <= down_in;
         count_ff   <= count_in;
      end
   end

   assign down_next = down_in;

endmodule

`default_nettype wire

/* hw/rtl/idm_meter.sv */
// Interlock-low interval meter keeping the longest interval
`default_nettype none

module idm_meter
   import idm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    take,
   input  wire req_type req,
   output meter_view_type view_next
);

   logic        enable_ff, enable_in;
   logic        closed_ff, closed_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] longest_ff, longest_in;
   logic [31:0] count_inc;

   // Advance the meter on accepted transactions
   always_comb begin
      enable_in  = enable_ff;
      closed_in  = closed_ff;
      count_in   = count_ff;
      longest_in = longest_ff;
      count_inc  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 32'd1;
      if (take) begin
         case (req.command)
            CMD_TICK: begin
               if (enable_ff) begin
                  if (closed_ff && !req.interlock_level) begin
                     count_in  = '0;
                     closed_in = 1'b0;
                  end else if (!closed_ff) begin
                     count_in = count_inc;
                     if (req.interlock_level) begin
                        closed_in = 1'b1;
                        if (count_inc > longest_ff) begin
                           longest_in = count_inc;
                        end
                     end
                  end
               end
            end
            CMD_START: begin
               longest_in = '0;
               enable_in  = 1'b1;
            end
            CMD_END: begin
               if (!closed_ff && (count_ff > longest_ff)) begin
                  longest_in = count_ff;
               end
               closed_in = 1'b1;
               enable_in = 1'b0;
            end
            default: begin
               // unused code: hold state
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         closed_ff  <= 1'b1;
         count_ff   <= '0;
         longest_ff <= '0;
      end else begin
         enable_ff  <= enable_in;
         closed_ff  <= closed_in;
         count_ff   <= count_in;
         longest_ff <= longest_in;
      end
   end

   assign view_next.measuring = enable_in;
   assign view_next.open      = !closed_in;
   assign view_next.longest   = longest_in;

endmodule

`default_nettype wire

/* hw/rtl/idm_checker.sv */
// Port-level checker for the interlock monitor, bound to the top level
`default_nettype none

`include "interlock_debounce_downtime_meter_assert.svh"

module idm_checker
   import idm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // Stalled result stays put
   `IDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Start clears the maximum and enables measuring
   `IDM_ASSERT_NEXT(a_start, clock, reset, req_valid && req_ready && (req_data.command == CMD_START), rsp_valid && rsp_data.measuring_active && (rsp_data.max_down_ms == 32'd0), "start transaction result wrong")

   // End closes the interval and disables measuring
   `IDM_ASSERT_NEXT(a_end, clock, reset, req_valid && req_ready && (req_data.command == CMD_END), rsp_valid && !rsp_data.measuring_active && !rsp_data.interval_open, "end transaction result wrong")

   // An interval is only open while measuring
   `IDM_ASSERT_NOW(a_open_measuring, clock, reset, rsp_valid && rsp_data.interval_open, rsp_data.measuring_active, "interval open while not measuring")

endmodule

bind interlock_debounce_downtime_meter idm_checker u_idm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
